// ===== sv/biou_pkg.sv =====
`timescale 1ns / 1ps

package biou_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // corner differences span -(2^C - 1) .. 2^C once the inclusive bit is added
  localparam int DIFF_BITS  = COORD_BITS + 2;
  // a positive width or height is at most 2^C
  localparam int SPAN_BITS  = COORD_BITS + 1;
  // areas are at most 2^(2C)
  localparam int AREA_BITS  = 2 * COORD_BITS + 1;
  localparam int UNION_BITS = AREA_BITS + 1;
  localparam int RATIO_BITS = FRAC_BITS + 1;
  // divider remainder holds twice the largest union
  localparam int REM_BITS   = UNION_BITS + 1;
  // one divider stage per quotient bit
  localparam int DIV_STAGES = RATIO_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_left;
    logic signed [COORD_BITS-1:0] a_top;
    logic signed [COORD_BITS-1:0] a_right;
    logic signed [COORD_BITS-1:0] a_bottom;
    logic signed [COORD_BITS-1:0] b_left;
    logic signed [COORD_BITS-1:0] b_top;
    logic signed [COORD_BITS-1:0] b_right;
    logic signed [COORD_BITS-1:0] b_bottom;
  } box_pair_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]  overlap_area;
    logic [UNION_BITS-1:0] combined_area;
    logic [RATIO_BITS-1:0] ratio_fixed;
  } iou_result_t;

  typedef struct packed {
    logic [AREA_BITS-1:0]  overlap_area;
    logic [UNION_BITS-1:0] combined_area;
    logic [UNION_BITS-1:0] divisor;
  } div_req_t;

endpackage

// ===== sv/biou_divider.sv =====
`timescale 1ns / 1ps

module biou_divider (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  biou_pkg::div_req_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output biou_pkg::iou_result_t out_data
);
  import biou_pkg::*;

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   rdy;
  logic [REM_BITS-1:0]   rem  [DIV_STAGES];
  logic [RATIO_BITS-1:0] quo  [DIV_STAGES];
  logic [UNION_BITS-1:0] dvs  [DIV_STAGES];
  logic [AREA_BITS-1:0]  ovl  [DIV_STAGES];
  logic [UNION_BITS-1:0] cmb  [DIV_STAGES];

  assign rdy[DIV_STAGES] = !out_stall;
  assign in_ready        = rdy[0];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                  src_valid;
    logic [REM_BITS-1:0]   trial;
    logic [RATIO_BITS-1:0] quo_in;
    logic [UNION_BITS-1:0] dvs_in;
    logic [AREA_BITS-1:0]  ovl_in;
    logic [UNION_BITS-1:0] cmb_in;
    logic                  take;

    if (s == 0) begin : g_first
      // integer bit: numerator against divisor, no shift
      assign src_valid = in_valid;
      assign trial     = {{(REM_BITS-AREA_BITS){1'b0}}, in_data.overlap_area};
      assign quo_in    = '0;
      assign dvs_in    = in_data.divisor;
      assign ovl_in    = in_data.overlap_area;
      assign cmb_in    = in_data.combined_area;
    end else begin : g_next
      assign src_valid = vld[s-1];
      assign trial     = {rem[s-1][REM_BITS-2:0], 1'b0};
      assign quo_in    = quo[s-1];
      assign dvs_in    = dvs[s-1];
      assign ovl_in    = ovl[s-1];
      assign cmb_in    = cmb[s-1];
    end

    assign take   = trial >= {1'b0, dvs_in};
    assign rdy[s] = !vld[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_valid) begin
        rem[s] <= take ? trial - {1'b0, dvs_in} : trial;
        quo[s] <= {quo_in[RATIO_BITS-2:0], take};
        dvs[s] <= dvs_in;
        ovl[s] <= ovl_in;
        cmb[s] <= cmb_in;
      end
    end
  end

  assign out_valid              = vld[DIV_STAGES-1];
  assign out_data.overlap_area  = ovl[DIV_STAGES-1];
  assign out_data.combined_area = cmb[DIV_STAGES-1];
  assign out_data.ratio_fixed   = quo[DIV_STAGES-1];

endmodule

// ===== sv/box_intersection_over_union.sv =====
`timescale 1ns / 1ps

// Intersection over union of two axis-aligned boxes. Takes one box pair per
// cycle while in_stall is low and returns intersection area, union area and
// the ratio as a fraction with FRAC_BITS fraction bits (floor). The pipeline
// has one stage for the overlap extents, one for the three area multiplies,
// one for the union, then a restoring divider that resolves one quotient bit
// per stage. Each stage holds its beat on its own valid bit, so a stall at
// the output lets earlier stages keep filling. Non-overlapping pairs give all
// zeros. inclusive_edges adds one to every width and height; change it only
// while the pipeline is empty.
module box_intersection_over_union (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  biou_pkg::box_pair_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output biou_pkg::iou_result_t out_data
);
  import biou_pkg::*;

  logic inclusive_edges;

  always_ff @(posedge clk) begin
    if (rst) begin
      inclusive_edges <= 1'b0;
    end else if (cfg_we) begin
      inclusive_edges <= cfg_data;
    end
  end

  logic ready1, ready2, ready3, div_ready;

  // stage 1: overlap extents and box spans
  logic signed [COORD_BITS-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [DIFF_BITS-1:0]  inc_s, iw_d, ih_d, wa_d, ha_d, wb_d, hb_d;
  logic                         hit_d;

  assign x_lo  = (in_data.a_left  > in_data.b_left)   ? in_data.a_left   : in_data.b_left;
  assign y_lo  = (in_data.a_top   > in_data.b_top)    ? in_data.a_top    : in_data.b_top;
  assign x_hi  = (in_data.a_right < in_data.b_right)  ? in_data.a_right  : in_data.b_right;
  assign y_hi  = (in_data.a_bottom < in_data.b_bottom) ? in_data.a_bottom : in_data.b_bottom;
  assign inc_s = $signed({{(DIFF_BITS-1){1'b0}}, inclusive_edges});

  assign iw_d = DIFF_BITS'(x_hi) - DIFF_BITS'(x_lo) + inc_s;
  assign ih_d = DIFF_BITS'(y_hi) - DIFF_BITS'(y_lo) + inc_s;
  assign wa_d = DIFF_BITS'(in_data.a_right)  - DIFF_BITS'(in_data.a_left) + inc_s;
  assign ha_d = DIFF_BITS'(in_data.a_bottom) - DIFF_BITS'(in_data.a_top)  + inc_s;
  assign wb_d = DIFF_BITS'(in_data.b_right)  - DIFF_BITS'(in_data.b_left) + inc_s;
  assign hb_d = DIFF_BITS'(in_data.b_bottom) - DIFF_BITS'(in_data.b_top)  + inc_s;

  // positive overlap implies both boxes have positive spans
  assign hit_d = !iw_d[DIFF_BITS-1] && (iw_d != '0) && !ih_d[DIFF_BITS-1] && (ih_d != '0);

  logic                 valid1, hit1;
  logic [SPAN_BITS-1:0] iw1, ih1, wa1, ha1, wb1, hb1;

  assign ready1   = !valid1 || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      hit1 <= hit_d;
      iw1  <= iw_d[SPAN_BITS-1:0];
      ih1  <= ih_d[SPAN_BITS-1:0];
      wa1  <= wa_d[SPAN_BITS-1:0];
      ha1  <= ha_d[SPAN_BITS-1:0];
      wb1  <= wb_d[SPAN_BITS-1:0];
      hb1  <= hb_d[SPAN_BITS-1:0];
    end
  end

  // stage 2: three area products
  logic [2*SPAN_BITS-1:0] inter_p, area_a_p, area_b_p;
  logic                   valid2, hit2;
  logic [AREA_BITS-1:0]   inter2, area_a2, area_b2;

  assign inter_p  = iw1 * ih1;
  assign area_a_p = wa1 * ha1;
  assign area_b_p = wb1 * hb1;
  assign ready2   = !valid2 || ready3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ready2) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && valid1) begin
      hit2    <= hit1;
      inter2  <= inter_p[AREA_BITS-1:0];
      area_a2 <= area_a_p[AREA_BITS-1:0];
      area_b2 <= area_b_p[AREA_BITS-1:0];
    end
  end

  // stage 3: union; a miss becomes 0 / 1 so the divider yields zero
  logic [UNION_BITS-1:0] union_d;
  logic                  valid3;
  div_req_t              req3;

  assign union_d = UNION_BITS'(area_a2) + UNION_BITS'(area_b2) - UNION_BITS'(inter2);
  assign ready3  = !valid3 || div_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (ready3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && valid2) begin
      if (hit2) begin
        req3.overlap_area  <= inter2;
        req3.combined_area <= union_d;
        req3.divisor       <= union_d;
      end else begin
        req3.overlap_area  <= '0;
        req3.combined_area <= '0;
        req3.divisor       <= UNION_BITS'(1);
      end
    end
  end

  biou_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid3),
    .in_ready  (div_ready),
    .in_data   (req3),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/box_intersection_over_union_tb.sv =====
`timescale 1ns / 1ps

module box_intersection_over_union_tb;
  import biou_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 3 + FRAC_BITS + 1 + 10;
  localparam int HOLD_LEN = 120;
  localparam int PHASE_ITEMS = 310;
  localparam int NUM_ROWS = 22;

  // ways of drawing one axis of a random box pair
  localparam int unsigned AX_SMALL = 0;
  localparam int unsigned AX_WIDE = 1;
  localparam int unsigned AX_NESTED = 2;
  localparam int unsigned AX_FLIPPED = 3;

  typedef struct {
    bit          edges;
    bit          fixed_want;
    box_pair_t   pair;
    iou_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  box_pair_t   in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  iou_result_t out_data;

  iou_result_t pending_results[$];
  bit          edges_mode = 1'b0;
  int          send_idle_pct = 24;
  int          recv_idle_pct = 81;
  int          mismatches = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;

  // corners are (left, top, right, bottom) for box a, then box b
  stim_row_t dir_rows [NUM_ROWS] = '{
    '{1'b0, 1'b1, '{0, 0, 10, 10, 0, 0, 10, 10}, '{100, 100, 65536}},
    '{1'b0, 1'b1, '{0, 0, 10, 10, 20, 20, 30, 30}, '{0, 0, 0}},
    '{1'b0, 1'b1, '{0, 0, 10, 10, 10, 0, 20, 10}, '{0, 0, 0}},
    '{1'b0, 1'b1, '{10, 10, 0, 0, 0, 0, 10, 10}, '{0, 0, 0}},
    '{1'b0, 1'b1, '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767},
      '{33'd4294836225, 34'd4294836225, 65536}},
    '{1'b0, 1'b0, '{0, 0, 10, 10, 5, 0, 15, 10}, '{0, 0, 0}},
    '{1'b0, 1'b0, '{0, 0, 2, 2, 1, 1, 3, 3}, '{0, 0, 0}},
    '{1'b0, 1'b0, '{-32768, -32768, 32767, 32767, 0, 0, 1, 1}, '{0, 0, 0}},
    '{1'b0, 1'b1, '{-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767},
      '{0, 0, 0}},
    '{1'b0, 1'b1, '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
      '{0, 0, 0}},
    '{1'b0, 1'b0, '{-32768, -32768, 32767, 32767, 32766, 32766, 32767, 32767},
      '{0, 0, 0}},
    '{1'b0, 1'b0, '{-100, -50, -10, -5, -60, -30, 20, 40}, '{0, 0, 0}},
    '{1'b0, 1'b1, '{0, 0, 10, 10, 0, 10, 10, 0}, '{0, 0, 0}},
    '{1'b1, 1'b1, '{5, 5, 5, 5, 5, 5, 5, 5}, '{1, 1, 65536}},
    '{1'b1, 1'b1, '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767},
      '{33'h1_0000_0000, 34'h1_0000_0000, 65536}},
    '{1'b1, 1'b0, '{-32768, -32768, 32767, 32767, 0, 0, 0, 0}, '{0, 0, 0}},
    '{1'b1, 1'b0, '{0, 0, 10, 10, 10, 0, 20, 10}, '{0, 0, 0}},
    '{1'b1, 1'b1, '{5, 5, 4, 4, 5, 5, 4, 4}, '{0, 0, 0}},
    '{1'b1, 1'b1, '{5, 5, 3, 3, 0, 0, 10, 10}, '{0, 0, 0}},
    '{1'b1, 1'b0, '{0, 0, 10, 10, 5, 0, 15, 10}, '{0, 0, 0}},
    '{1'b1, 1'b0, '{-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768},
      '{0, 0, 0}},
    '{1'b0, 1'b1, '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767},
      '{33'd4294836225, 34'd4294836225, 65536}}
  };

  box_intersection_over_union dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic iou_result_t iou_of(box_pair_t p, bit edges);
    longint inc, w, h, inter, area_a, area_b, uni;
    iou_result_t r;
    inc = edges;
    r = '0;
    w = ((p.a_right < p.b_right) ? p.a_right : p.b_right)
        - ((p.a_left > p.b_left) ? p.a_left : p.b_left) + inc;
    h = ((p.a_bottom < p.b_bottom) ? p.a_bottom : p.b_bottom)
        - ((p.a_top > p.b_top) ? p.a_top : p.b_top) + inc;
    if (w <= 0 || h <= 0) return r;
    inter = w * h;
    area_a = (p.a_right - p.a_left + inc) * (p.a_bottom - p.a_top + inc);
    area_b = (p.b_right - p.b_left + inc) * (p.b_bottom - p.b_top + inc);
    uni = area_a + area_b - inter;
    r.overlap_area = AREA_BITS'(inter);
    if (uni <= 0) return r;
    r.combined_area = UNION_BITS'(uni);
    if (inter <= uni) r.ratio_fixed = RATIO_BITS'((inter <<< FRAC_BITS) / uni);
    return r;
  endfunction

  // extremes show up often enough to hit the corners of the range
  function automatic int rand_coord();
    int unsigned k;
    k = $urandom_range(9);
    if (k == 0) return -32768;
    if (k == 1) return 32767;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic void rand_axis(int unsigned mode, output int a0, a1, b0, b1);
    int t, base, len;
    case (mode)
      AX_SMALL: begin
        base = int'($urandom_range(65535 - 1400)) - 32768 + 700;
        a0 = base;
        a1 = base + int'($urandom_range(300));
        b0 = base - 300 + int'($urandom_range(a1 - base + 301));
        b1 = b0 + int'($urandom_range(300));
      end
      AX_NESTED: begin
        a0 = rand_coord();
        a1 = rand_coord();
        if (a1 < a0) begin
          t = a0; a0 = a1; a1 = t;
        end
        len = (a1 - a0) / 2;
        b0 = a0 + int'($urandom_range(len));
        b1 = a1 - int'($urandom_range(len));
      end
      default: begin
        a0 = rand_coord();
        a1 = rand_coord();
        b0 = rand_coord();
        b1 = rand_coord();
        if (a1 < a0) begin
          t = a0; a0 = a1; a1 = t;
        end
        if (b1 < b0) begin
          t = b0; b0 = b1; b1 = t;
        end
        if (mode == AX_FLIPPED) begin
          t = a0; a0 = a1; a1 = t;
        end
      end
    endcase
  endfunction

  function automatic box_pair_t random_pair();
    int unsigned pick, m;
    int xa0, xa1, xb0, xb1, ya0, ya1, yb0, yb1;
    box_pair_t p;
    pick = $urandom_range(99);
    if (pick < 12) begin
      p = {$urandom, $urandom, $urandom, $urandom};
      return p;
    end
    m = (pick < 65) ? AX_SMALL : (pick < 82) ? AX_WIDE : (pick < 94) ? AX_NESTED : AX_FLIPPED;
    rand_axis(m, xa0, xa1, xb0, xb1);
    rand_axis((m == AX_FLIPPED) ? AX_WIDE : m, ya0, ya1, yb0, yb1);
    p.a_left = COORD_BITS'(xa0);
    p.a_right = COORD_BITS'(xa1);
    p.b_left = COORD_BITS'(xb0);
    p.b_right = COORD_BITS'(xb1);
    p.a_top = COORD_BITS'(ya0);
    p.a_bottom = COORD_BITS'(ya1);
    p.b_top = COORD_BITS'(yb0);
    p.b_bottom = COORD_BITS'(yb1);
    return p;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic check_beat(iou_result_t got);
    iou_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected beat, overlap_area", got.overlap_area, 0);
      return;
    end
    want = pending_results.pop_front();
    if (got.overlap_area !== want.overlap_area)
      report_mismatch("overlap_area", got.overlap_area, want.overlap_area);
    if (got.combined_area !== want.combined_area)
      report_mismatch("combined_area", got.combined_area, want.combined_area);
    if (got.ratio_fixed !== want.ratio_fixed)
      report_mismatch("ratio_fixed", got.ratio_fixed, want.ratio_fixed);
  endtask

  // valid stays up after the accepting edge; the next call or the caller
  // decides what it does on the following cycle
  task automatic send_pair(box_pair_t p, bit fixed_want, iou_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(fixed_want ? want : iou_of(p, edges_mode));
  endtask

  task automatic set_edges(bit v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    edges_mode = v;
  endtask

  task automatic run_phase(int s_idle, int r_idle, bit v, bit with_hold);
    int i;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    set_edges(v);
    if (with_hold) hold_go <= 1'b1;
    for (i = 0; i < PHASE_ITEMS; i++) send_pair(random_pair(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      // long hold-off so the pipeline backs up into the input
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
    if (!rst && out_valid && !out_stall) begin
      check_beat(out_data);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_edges(dir_rows[0].edges);
    for (k = 0; k < NUM_ROWS; k++) begin
      if (dir_rows[k].edges != edges_mode) set_edges(dir_rows[k].edges);
      send_pair(dir_rows[k].pair, dir_rows[k].fixed_want, dir_rows[k].want);
    end
    run_phase(24, 81, 1'b1, 1'b0);
    run_phase(81, 24, 1'b0, 1'b0);
    run_phase(0, 0, 1'b1, 1'b1);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
